// ===== rtl/rx_link_stats_collector_assert.svh =====
// Assertion macros shared by the receive statistics collector RTL.
// Expects clock and reset in the including scope; included by the files that assert.
`ifndef RX_LINK_STATS_COLLECTOR_ASSERT_SVH
`define RX_LINK_STATS_COLLECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define RLSC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define RLSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rlsc_pkg.sv =====
// Types and constants of the receive statistics collector.
// Depends on nothing; imported by rlsc_ambient, rx_link_stats_collector and the testbench.
package rlsc_pkg;

   // Request action codes
   typedef enum logic [2:0] {
      ACT_FRAME    = 3'd0,
      ACT_ADD_PEER = 3'd1,
      ACT_CLR_PEER = 3'd2,
      ACT_RD_PEER  = 3'd3,
      ACT_CLR_AMB  = 3'd4,
      ACT_RD_AMB   = 3'd5
   } rlsc_action_type;

   // Response status codes
   localparam logic [2:0] STS_OK        = 3'd0;
   localparam logic [2:0] STS_UNMATCHED = 3'd1;
   localparam logic [2:0] STS_DUPLICATE = 3'd2;
   localparam logic [2:0] STS_FULL      = 3'd3;
   localparam logic [2:0] STS_BAD_INDEX = 3'd4;

   // Ambient noise floor extremes after reset or clear
   localparam logic signed [7:0] NF_MIN_INIT = 8'sh7F;
   localparam logic signed [7:0] NF_MAX_INIT = 8'sh80;

   // One peer statistics entry as stored in memory
   typedef struct packed {
      logic [31:0]        count;
      logic signed [31:0] sig_sum;
      logic signed [31:0] nf_sum;
      logic signed [7:0]  sig_low;
      logic signed [7:0]  sig_high;
      logic [31:0]        rate_bits;
      logic [15:0]        first_seq;
      logic [15:0]        last_seq;
      logic               seq_seen;
   } rlsc_stat_type;

   // Ambient statistics
   typedef struct packed {
      logic [31:0]        count;
      logic signed [31:0] nf_sum;
      logic signed [31:0] sig_sum;
      logic signed [7:0]  nf_min;
      logic signed [7:0]  nf_max;
   } rlsc_amb_type;

   // Commands to the ambient unit
   typedef struct packed {
      logic update;
      logic clear;
   } rlsc_amb_cmd_type;

   // One response
   typedef struct packed {
      logic [2:0]         status;
      logic [2:0]         peer_index;
      logic [31:0]        count;
      logic signed [31:0] sig_sum;
      logic signed [31:0] nf_sum;
      logic signed [7:0]  low_value;
      logic signed [7:0]  high_value;
      logic [31:0]        rate_mask;
      logic [15:0]        first_seq;
      logic [15:0]        last_seq;
   } rlsc_rsp_type;

endpackage

// ===== rtl/rlsc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module rlsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/rlsc_ambient.sv =====
// Ambient statistics registers: frame count, sums and noise floor extremes.
// Depends on rlsc_pkg.
module rlsc_ambient
   import rlsc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  rlsc_amb_cmd_type  cmd,
   input  logic signed [7:0] rssi,
   input  logic signed [7:0] frame_nf,
   output rlsc_amb_type      amb
);

   rlsc_amb_type amb_ff;
   rlsc_amb_type amb_in;

   // Accumulate one frame, or return to the cleared values
   always_comb begin
      amb_in = amb_ff;
      if (cmd.clear) begin
         amb_in.count   = '0;
         amb_in.nf_sum  = '0;
         amb_in.sig_sum = '0;
         amb_in.nf_min  = NF_MIN_INIT;
         amb_in.nf_max  = NF_MAX_INIT;
      end else if (cmd.update) begin
         amb_in.count   = amb_ff.count + 32'd1;
         amb_in.nf_sum  = amb_ff.nf_sum + {{24{frame_nf[7]}}, frame_nf};
         amb_in.sig_sum = amb_ff.sig_sum + {{24{rssi[7]}}, rssi};
         if (frame_nf < amb_ff.nf_min) begin
            amb_in.nf_min = frame_nf;
         end
         if (frame_nf > amb_ff.nf_max) begin
            amb_in.nf_max = frame_nf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         amb_ff.count   <= '0;
         amb_ff.nf_sum  <= '0;
         amb_ff.sig_sum <= '0;
         amb_ff.nf_min  <= NF_MIN_INIT;
         amb_ff.nf_max  <= NF_MAX_INIT;
      end else begin
         amb_ff <= amb_in;
      end
   end

   assign amb = amb_ff;

endmodule

// ===== rtl/rx_link_stats_collector.sv =====
// Receive statistics collector: a table of registered peer addresses with
// per-peer statistics held in two synchronous RAMs, plus ambient statistics.
// Depends on rlsc_pkg, rlsc_ram, rlsc_ambient and the assertion macro header.
//
// A request is taken when start is high and busy is low; its single response
// appears for exactly one cycle with rsp_strobe, in the cycle after the request
// finishes, and cannot be held off. Clear, ambient and rejected-read requests
// and frames without a test header keep busy low, so a new request can be
// taken every cycle. A peer read is busy while the statistics RAM is read.
// Frames with a header and peer adds walk the address RAM slot by slot, reading
// then comparing each slot: a match ends the walk in its compare state, a miss
// ends it once every registered slot is compared. The matched entry is read with
// its address and written back in the compare cycle. Peer statistics are cleared
// by a flip-flop valid bit per slot, so no clearing pass follows reset.
`include "rx_link_stats_collector_assert.svh"

module rx_link_stats_collector
   import rlsc_pkg::*;
#(
   parameter int PEER_SLOTS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_action,
   input  logic [47:0]        req_mac,
   input  logic signed [7:0]  req_rssi,
   input  logic signed [7:0]  req_nf_level,
   input  logic [4:0]         req_rate,
   input  logic [15:0]        req_seq,
   input  logic               req_has_header,
   input  logic [2:0]         req_peer_select,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_status,
   output logic [2:0]         rsp_peer_index,
   output logic [31:0]        rsp_count,
   output logic signed [31:0] rsp_sig_sum,
   output logic signed [31:0] rsp_nf_sum,
   output logic signed [7:0]  rsp_low_value,
   output logic signed [7:0]  rsp_high_value,
   output logic [31:0]        rsp_rate_mask,
   output logic [15:0]        rsp_first_seq,
   output logic [15:0]        rsp_last_seq
);

   localparam int IDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
   localparam int CNT_W = $clog2(PEER_SLOTS + 1);
   localparam int CMP_W = (CNT_W > 3) ? CNT_W : 3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CMP,
      ST_READ
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic [CNT_W-1:0]     total_ff, total_in;
   logic [PEER_SLOTS-1:0] valid_ff, valid_in;
   rlsc_rsp_type         rsp_ff, rsp_in;
   logic                 strobe_ff, strobe_in;

   // Latched request
   logic [2:0]           action_ff;
   logic [47:0]          mac_ff;
   logic signed [7:0]    rssi_ff;
   logic signed [7:0]    nf_ff;
   logic [4:0]           rate_ff;
   logic [15:0]          seq_ff;
   logic [2:0]           sel_ff;

   logic                 accept;
   logic [IDX_W-1:0]     scan_idx;
   logic                 sel_in_range;

   logic                 addr_we;
   logic [47:0]          addr_rd;
   logic                 stat_we;
   logic [IDX_W-1:0]     stat_raddr;
   rlsc_stat_type        stat_rd;
   rlsc_stat_type        stat_old;
   rlsc_stat_type        stat_new;
   rlsc_stat_type        stat_read;

   rlsc_amb_cmd_type     amb_cmd;
   rlsc_amb_type         amb;

   assign busy         = (state_ff != ST_IDLE);
   assign accept       = start && !busy;
   assign scan_idx     = IDX_W'(scan_ff);
   assign sel_in_range = CMP_W'(req_peer_select) < CMP_W'(total_ff);
   assign stat_raddr   = (state_ff == ST_IDLE) ? IDX_W'(req_peer_select) : scan_idx;

   // Address table, written at the next free slot
   rlsc_ram #(
      .WIDTH (48),
      .DEPTH (PEER_SLOTS)
   ) u_addr_ram (
      .clock (clock),
      .we    (addr_we),
      .waddr (IDX_W'(total_ff)),
      .wdata (mac_ff),
      .raddr (scan_idx),
      .rdata (addr_rd)
   );

   // Peer statistics, read with the address and written back on a match
   rlsc_ram #(
      .WIDTH ($bits(rlsc_stat_type)),
      .DEPTH (PEER_SLOTS)
   ) u_stat_ram (
      .clock (clock),
      .we    (stat_we),
      .waddr (scan_idx),
      .wdata (stat_new),
      .raddr (stat_raddr),
      .rdata (stat_rd)
   );

   rlsc_ambient u_ambient (
      .clock    (clock),
      .reset    (reset),
      .cmd      (amb_cmd),
      .rssi     (req_rssi),
      .frame_nf (req_nf_level),
      .amb      (amb)
   );

   // Mask entries cleared since their last write
   assign stat_old  = valid_ff[scan_idx] ? stat_rd : '0;
   assign stat_read = valid_ff[IDX_W'(sel_ff)] ? stat_rd : '0;

   // Fold one frame into the matched peer entry
   always_comb begin
      stat_new = stat_old;
      if (stat_old.count == 32'd0 || rssi_ff < stat_old.sig_low) begin
         stat_new.sig_low = rssi_ff;
      end
      if (stat_old.count == 32'd0 || rssi_ff > stat_old.sig_high) begin
         stat_new.sig_high = rssi_ff;
      end
      stat_new.sig_sum   = stat_old.sig_sum + {{24{rssi_ff[7]}}, rssi_ff};
      stat_new.nf_sum    = stat_old.nf_sum + {{24{nf_ff[7]}}, nf_ff};
      stat_new.rate_bits = stat_old.rate_bits | (32'd1 << rate_ff);
      if (!stat_old.seq_seen) begin
         stat_new.first_seq = seq_ff;
         stat_new.seq_seen  = 1'b1;
      end
      stat_new.last_seq = seq_ff;
      stat_new.count    = stat_old.count + 32'd1;
   end

   // Sequencer: dispatch requests, walk the table, build the response
   always_comb begin
      state_in  = state_ff;
      scan_in   = scan_ff;
      total_in  = total_ff;
      valid_in  = valid_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      addr_we   = 1'b0;
      stat_we   = 1'b0;
      amb_cmd   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_FRAME: begin
                     amb_cmd.update = 1'b1;
                     if (req_has_header) begin
                        scan_in  = '0;
                        state_in = ST_SCAN;
                     end else begin
                        rsp_in        = '0;
                        rsp_in.status = STS_UNMATCHED;
                        strobe_in     = 1'b1;
                     end
                  end
                  ACT_ADD_PEER: begin
                     scan_in  = '0;
                     state_in = ST_SCAN;
                  end
                  ACT_CLR_PEER: begin
                     valid_in  = '0;
                     rsp_in    = '0;
                     strobe_in = 1'b1;
                  end
                  ACT_RD_PEER: begin
                     if (sel_in_range) begin
                        state_in = ST_READ;
                     end else begin
                        rsp_in            = '0;
                        rsp_in.status     = STS_BAD_INDEX;
                        rsp_in.peer_index = req_peer_select;
                        strobe_in         = 1'b1;
                     end
                  end
                  ACT_CLR_AMB: begin
                     amb_cmd.clear = 1'b1;
                     rsp_in        = '0;
                     strobe_in     = 1'b1;
                  end
                  ACT_RD_AMB: begin
                     rsp_in            = '0;
                     rsp_in.count      = amb.count;
                     rsp_in.sig_sum    = amb.sig_sum;
                     rsp_in.nf_sum     = amb.nf_sum;
                     rsp_in.low_value  = amb.nf_min;
                     rsp_in.high_value = amb.nf_max;
                     strobe_in         = 1'b1;
                  end
                  default: begin
                     rsp_in    = '0;
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_ff == total_ff) begin
               // No registered peer holds this address
               rsp_in    = '0;
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
               if (action_ff == ACT_FRAME) begin
                  rsp_in.status = STS_UNMATCHED;
               end else if (total_ff == CNT_W'(PEER_SLOTS)) begin
                  rsp_in.status = STS_FULL;
               end else begin
                  addr_we                   = 1'b1;
                  valid_in[IDX_W'(total_ff)] = 1'b0;
                  total_in                  = CNT_W'(total_ff + 1'b1);
                  rsp_in.peer_index         = 3'(total_ff);
               end
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (addr_rd == mac_ff) begin
               rsp_in            = '0;
               rsp_in.peer_index = 3'(scan_ff);
               strobe_in         = 1'b1;
               state_in          = ST_IDLE;
               if (action_ff == ACT_FRAME) begin
                  stat_we            = 1'b1;
                  valid_in[scan_idx] = 1'b1;
               end else begin
                  rsp_in.status = STS_DUPLICATE;
               end
            end else begin
               scan_in  = CNT_W'(scan_ff + 1'b1);
               state_in = ST_SCAN;
            end
         end
         ST_READ: begin
            rsp_in            = '0;
            rsp_in.peer_index = sel_ff;
            rsp_in.count      = stat_read.count;
            rsp_in.sig_sum    = stat_read.sig_sum;
            rsp_in.nf_sum     = stat_read.nf_sum;
            rsp_in.low_value  = stat_read.sig_low;
            rsp_in.high_value = stat_read.sig_high;
            rsp_in.rate_mask  = stat_read.rate_bits;
            rsp_in.first_seq  = stat_read.first_seq;
            rsp_in.last_seq   = stat_read.last_seq;
            strobe_in         = 1'b1;
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, table occupancy and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         scan_ff   <= '0;
         total_ff  <= '0;
         valid_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         scan_ff   <= scan_in;
         total_ff  <= total_in;
         valid_ff  <= valid_in;
         strobe_ff <= strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   // Capture the request on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         mac_ff    <= req_mac;
         rssi_ff   <= req_rssi;
         nf_ff     <= req_nf_level;
         rate_ff   <= req_rate;
         seq_ff    <= req_seq;
         sel_ff    <= req_peer_select;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_peer_index = rsp_ff.peer_index;
   assign rsp_count      = rsp_ff.count;
   assign rsp_sig_sum    = rsp_ff.sig_sum;
   assign rsp_nf_sum     = rsp_ff.nf_sum;
   assign rsp_low_value  = rsp_ff.low_value;
   assign rsp_high_value = rsp_ff.high_value;
   assign rsp_rate_mask  = rsp_ff.rate_mask;
   assign rsp_first_seq  = rsp_ff.first_seq;
   assign rsp_last_seq   = rsp_ff.last_seq;

   // A response follows only an accepted request or a busy cycle
   `RLSC_ASSERT_NOW(a_rsp_has_cause, strobe_ff, $past(busy) || $past(accept), "stray response")
   // A statistics write ends the request with its response
   `RLSC_ASSERT_NEXT(a_write_ends, stat_we, state_ff == ST_IDLE && strobe_ff, "write left busy")
   // A new address is written only into a free slot
   `RLSC_ASSERT_NOW(a_add_has_room, addr_we, total_ff < CNT_W'(PEER_SLOTS), "table overflow")
   // Compare only against registered slots
   `RLSC_ASSERT_NOW(a_cmp_in_table, state_ff == ST_CMP, scan_ff < total_ff, "compare past table")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for rx_link_stats_collector: directed and random requests
// against a built-in predictor of the peer and ambient statistics.
// Depends on rlsc_pkg and the rx_link_stats_collector RTL.
`timescale 1ns / 100ps

module tb
   import rlsc_pkg::*;
();

   localparam int PEER_SLOTS      = 8;
   localparam int RANDOM_REQUESTS = 930;
   localparam int QUIET_LIMIT     = 1000;
   localparam int DRAIN_CYCLES    = 40;
   localparam int CALM_TAIL       = 150;

   // Action codes that the block must ignore
   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               start           = 1'b0;
   logic               busy;
   logic [2:0]         req_action      = '0;
   logic [47:0]        req_mac         = '0;
   logic signed [7:0]  req_rssi        = '0;
   logic signed [7:0]  req_nf_level    = '0;
   logic [4:0]         req_rate        = '0;
   logic [15:0]        req_seq         = '0;
   logic               req_has_header  = 1'b0;
   logic [2:0]         req_peer_select = '0;
   logic               rsp_strobe;
   logic [2:0]         rsp_status;
   logic [2:0]         rsp_peer_index;
   logic [31:0]        rsp_count;
   logic signed [31:0] rsp_sig_sum;
   logic signed [31:0] rsp_nf_sum;
   logic signed [7:0]  rsp_low_value;
   logic signed [7:0]  rsp_high_value;
   logic [31:0]        rsp_rate_mask;
   logic [15:0]        rsp_first_seq;
   logic [15:0]        rsp_last_seq;

   // Predicted block state
   logic [47:0]   peer_mac [PEER_SLOTS];
   int            registered_peers;
   rlsc_stat_type peer_stats [PEER_SLOTS];
   rlsc_amb_type  ambient;

   rlsc_rsp_type  pending_stats_rsp [$];
   int            mismatch_count = 0;
   int            quiet_cycles   = 0;

   rx_link_stats_collector #(.PEER_SLOTS(PEER_SLOTS)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_mac        (req_mac),
      .req_rssi       (req_rssi),
      .req_nf_level   (req_nf_level),
      .req_rate       (req_rate),
      .req_seq        (req_seq),
      .req_has_header (req_has_header),
      .req_peer_select(req_peer_select),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_peer_index (rsp_peer_index),
      .rsp_count      (rsp_count),
      .rsp_sig_sum    (rsp_sig_sum),
      .rsp_nf_sum     (rsp_nf_sum),
      .rsp_low_value  (rsp_low_value),
      .rsp_high_value (rsp_high_value),
      .rsp_rate_mask  (rsp_rate_mask),
      .rsp_first_seq  (rsp_first_seq),
      .rsp_last_seq   (rsp_last_seq)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Restore ambient statistics to their cleared values
   function automatic void clear_ambient_model();
      ambient.count   = '0;
      ambient.nf_sum  = '0;
      ambient.sig_sum = '0;
      ambient.nf_min  = NF_MIN_INIT;
      ambient.nf_max  = NF_MAX_INIT;
   endfunction

   function automatic int find_peer_slot(logic [47:0] mac);
      for (int i = 0; i < registered_peers; i++)
         if (peer_mac[i] == mac) return i;
      return -1;
   endfunction

   // Work out the response to one request and advance the predicted state
   function automatic rlsc_rsp_type predict_link_stats(
      logic [2:0] action, logic [47:0] mac, logic signed [7:0] rssi,
      logic signed [7:0] nf, logic [4:0] rate, logic [15:0] seq, logic hdr,
      logic [2:0] sel);
      rlsc_rsp_type       r;
      int                 slot;
      logic signed [31:0] rssi_w;
      logic signed [31:0] nf_w;
      r      = '0;
      rssi_w = {{24{rssi[7]}}, rssi};
      nf_w   = {{24{nf[7]}}, nf};
      case (action)
         ACT_FRAME: begin
            ambient.count   = ambient.count + 32'd1;
            ambient.nf_sum  = ambient.nf_sum + nf_w;
            ambient.sig_sum = ambient.sig_sum + rssi_w;
            if ($signed(nf) < $signed(ambient.nf_min)) ambient.nf_min = nf;
            if ($signed(nf) > $signed(ambient.nf_max)) ambient.nf_max = nf;
            slot = hdr ? find_peer_slot(mac) : -1;
            if (slot < 0) begin
               r.status = STS_UNMATCHED;
            end else begin
               // a peer with no frames takes this frame's signal as both extremes
               if (peer_stats[slot].count == 0) begin
                  peer_stats[slot].sig_low  = rssi;
                  peer_stats[slot].sig_high = rssi;
               end
               if ($signed(rssi) < $signed(peer_stats[slot].sig_low))
                  peer_stats[slot].sig_low = rssi;
               if ($signed(rssi) > $signed(peer_stats[slot].sig_high))
                  peer_stats[slot].sig_high = rssi;
               peer_stats[slot].sig_sum   = peer_stats[slot].sig_sum + rssi_w;
               peer_stats[slot].nf_sum    = peer_stats[slot].nf_sum + nf_w;
               peer_stats[slot].rate_bits = peer_stats[slot].rate_bits | (32'd1 << rate);
               if (!peer_stats[slot].seq_seen) begin
                  peer_stats[slot].first_seq = seq;
                  peer_stats[slot].seq_seen  = 1'b1;
               end
               peer_stats[slot].last_seq = seq;
               peer_stats[slot].count    = peer_stats[slot].count + 32'd1;
               r.status     = STS_OK;
               r.peer_index = slot[2:0];
            end
         end
         ACT_ADD_PEER: begin
            slot = find_peer_slot(mac);
            if (slot >= 0) begin
               r.status     = STS_DUPLICATE;
               r.peer_index = slot[2:0];
            end else if (registered_peers >= PEER_SLOTS) begin
               r.status = STS_FULL;
            end else begin
               peer_mac[registered_peers]   = mac;
               peer_stats[registered_peers] = '0;
               r.peer_index = 3'(registered_peers);
               registered_peers++;
            end
         end
         ACT_CLR_PEER: begin
            for (int i = 0; i < PEER_SLOTS; i++) peer_stats[i] = '0;
         end
         ACT_RD_PEER: begin
            r.peer_index = sel;
            if (int'(sel) >= registered_peers) begin
               r.status = STS_BAD_INDEX;
            end else begin
               r.count      = peer_stats[sel].count;
               r.sig_sum    = peer_stats[sel].sig_sum;
               r.nf_sum     = peer_stats[sel].nf_sum;
               r.low_value  = peer_stats[sel].sig_low;
               r.high_value = peer_stats[sel].sig_high;
               r.rate_mask  = peer_stats[sel].rate_bits;
               r.first_seq  = peer_stats[sel].first_seq;
               r.last_seq   = peer_stats[sel].last_seq;
            end
         end
         ACT_CLR_AMB: begin
            clear_ambient_model();
         end
         ACT_RD_AMB: begin
            r.count      = ambient.count;
            r.sig_sum    = ambient.sig_sum;
            r.nf_sum     = ambient.nf_sum;
            r.low_value  = ambient.nf_min;
            r.high_value = ambient.nf_max;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // Drive one request, hold it until taken, then queue its expected response
   task automatic send_request(input logic [2:0] action, input logic [47:0] mac,
                               input logic signed [7:0] rssi, input logic signed [7:0] nf,
                               input logic [4:0] rate, input logic [15:0] seq,
                               input logic hdr, input logic [2:0] sel);
      start           <= 1'b1;
      req_action      <= action;
      req_mac         <= mac;
      req_rssi        <= rssi;
      req_nf_level    <= nf;
      req_rate        <= rate;
      req_seq         <= seq;
      req_has_header  <= hdr;
      req_peer_select <= sel;
      do @(posedge clock); while (busy);
      pending_stats_rsp.push_back(predict_link_stats(action, mac, rssi, nf, rate, seq,
                                                     hdr, sel));
   endtask

   // Drop start for a few cycles
   task automatic pause_requests(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Compare each response with the oldest expectation
   always @(posedge clock) begin
      rlsc_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_stats_rsp.size() == 0) begin
            $error("response with status %0h arrived with nothing expected", rsp_status);
            mismatch_count++;
         end else begin
            want = pending_stats_rsp.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("peer_index", want.peer_index, rsp_peer_index);
            check_field("count", want.count, rsp_count);
            check_field("rssi_sum", want.sig_sum, rsp_sig_sum);
            check_field("nf_sum", want.nf_sum, rsp_nf_sum);
            check_field("low_value", want.low_value, rsp_low_value);
            check_field("high_value", want.high_value, rsp_high_value);
            check_field("rate_mask", want.rate_mask, rsp_rate_mask);
            check_field("first_seq", want.first_seq, rsp_first_seq);
            check_field("last_seq", want.last_seq, rsp_last_seq);
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Ambient reset values, empty table, spare actions
   task automatic test_reset_state();
      send_request(ACT_RD_AMB, 48'h0, 8'sd0, 8'sd0, 5'd0, 16'h0, 1'b0, 3'd0);
      send_request(ACT_RD_PEER, 48'h0, 8'sd0, 8'sd0, 5'd0, 16'h0, 1'b1, 3'd0);
      send_request(ACT_FRAME, 48'h0, -8'sd128, 8'sd127, 5'd31, 16'hFFFF, 1'b1, 3'd7);
      send_request(ACT_RD_AMB, 48'hFFFF_FFFF_FFFF, 8'sd0, 8'sd0, 5'd0, 16'h0, 1'b0, 3'd7);
      send_request(ACT_SPARE_6, 48'hFFFF_FFFF_FFFF, 8'sd127, -8'sd128, 5'd31, 16'hFFFF,
                   1'b1, 3'd7);
      send_request(ACT_SPARE_7, 48'h5555_AAAA_5555, -8'sd1, 8'sd1, 5'd17, 16'h8001,
                   1'b0, 3'd5);
   endtask

   // Adds, duplicates, a full table, matched and headerless frames, clears
   task automatic test_peer_table();
      logic [47:0] mac;
      send_request(ACT_ADD_PEER, 48'h0, 8'sd0, 8'sd0, 5'd0, 16'h0, 1'b0, 3'd0);
      send_request(ACT_ADD_PEER, 48'hFFFF_FFFF_FFFF, 8'sd0, 8'sd0, 5'd0, 16'h0, 1'b1, 3'd0);
      send_request(ACT_ADD_PEER, 48'h0, 8'sd0, 8'sd0, 5'd0, 16'h0, 1'b1, 3'd0);
      send_request(ACT_FRAME, 48'hFFFF_FFFF_FFFF, 8'sd127, -8'sd128, 5'd31, 16'hFFFF,
                   1'b1, 3'd0);
      send_request(ACT_FRAME, 48'hFFFF_FFFF_FFFF, 8'sd5, 8'sd5, 5'd3, 16'h1234, 1'b0, 3'd0);
      send_request(ACT_FRAME, 48'h0, -8'sd128, 8'sd127, 5'd0, 16'h0, 1'b1, 3'd0);
      send_request(ACT_RD_PEER, 48'h0, 8'sd0, 8'sd0, 5'd0, 16'h0, 1'b0, 3'd0);
      send_request(ACT_RD_PEER, 48'h0, 8'sd0, 8'sd0, 5'd0, 16'h0, 1'b0, 3'd1);
      send_request(ACT_RD_PEER, 48'h0, 8'sd0, 8'sd0, 5'd0, 16'h0, 1'b0, 3'd7);
      // fill the remaining slots, then one more add
      while (registered_peers < PEER_SLOTS) begin
         mac = {16'($urandom), $urandom};
         send_request(ACT_ADD_PEER, mac, 8'sd0, 8'sd0, 5'd0, 16'h0, 1'b0, 3'd0);
      end
      send_request(ACT_ADD_PEER, 48'h0123_4567_89AB, 8'sd0, 8'sd0, 5'd0, 16'h0, 1'b0, 3'd0);
      send_request(ACT_RD_PEER, 48'h0, 8'sd0, 8'sd0, 5'd0, 16'h0, 1'b0, 3'd7);
      send_request(ACT_CLR_PEER, 48'h0, 8'sd0, 8'sd0, 5'd0, 16'h0, 1'b0, 3'd0);
      send_request(ACT_RD_PEER, 48'h0, 8'sd0, 8'sd0, 5'd0, 16'h0, 1'b0, 3'd1);
      send_request(ACT_CLR_AMB, 48'h0, 8'sd0, 8'sd0, 5'd0, 16'h0, 1'b0, 3'd0);
      send_request(ACT_RD_AMB, 48'h0, 8'sd0, 8'sd0, 5'd0, 16'h0, 1'b0, 3'd0);
   endtask

   // Mostly frames from registered peers, mixed with reads, clears and noise
   task automatic test_random_traffic(input int total);
      logic [2:0]        action;
      logic [47:0]       mac;
      logic signed [7:0] rssi;
      logic signed [7:0] nf;
      logic              hdr;
      int                pick;
      bit                gaps_on;
      gaps_on = 1'b0;
      for (int k = 0; k < total; k++) begin
         // switch idling on or off per stretch, never near the end
         if (k % 40 == 0) gaps_on = (k < total - CALM_TAIL) && ($urandom_range(0, 2) != 0);
         if (gaps_on && $urandom_range(0, 3) == 0) pause_requests($urandom_range(1, 5));
         mac  = {16'($urandom), $urandom};
         rssi = 8'($urandom);
         nf   = 8'($urandom);
         hdr  = 1'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 62) begin
            action = ACT_FRAME;
            if (registered_peers > 0 && $urandom_range(0, 9) < 8) begin
               mac = peer_mac[$urandom_range(0, registered_peers - 1)];
               hdr = ($urandom_range(0, 9) != 0);
            end
         end else if (pick < 66) begin
            action = ACT_ADD_PEER;
            if (registered_peers > 0 && $urandom_range(0, 1) == 0)
               mac = peer_mac[$urandom_range(0, registered_peers - 1)];
         end else if (pick < 68) begin
            action = ACT_CLR_PEER;
         end else if (pick < 84) begin
            action = ACT_RD_PEER;
         end else if (pick < 86) begin
            action = ACT_CLR_AMB;
         end else if (pick < 96) begin
            action = ACT_RD_AMB;
         end else begin
            action = ($urandom_range(0, 1) == 0) ? ACT_SPARE_6 : ACT_SPARE_7;
         end
         send_request(action, mac, rssi, nf, 5'($urandom), 16'($urandom), hdr,
                      3'($urandom));
      end
   endtask

   initial begin
      for (int i = 0; i < PEER_SLOTS; i++) begin
         peer_mac[i]   = '0;
         peer_stats[i] = '0;
      end
      registered_peers = 0;
      clear_ambient_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_peer_table();
      test_random_traffic(RANDOM_REQUESTS);
      start <= 1'b0;
      while (pending_stats_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_stats_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
